// ----- rtl/mrrc_pkg.sv -----
`default_nettype none

package mrrc_pkg;

    // Register map (word index = paddr[3:2])
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0]  REG_SLAVE_ID  = 2'd0;
    localparam logic [1:0]  REG_FUNCTION  = 2'd1;
    localparam logic [1:0]  REG_REG_COUNT = 2'd2;

    // Register reset values
    localparam logic [7:0] SLAVE_ID_RST  = 8'd1;
    localparam logic [7:0] FUNCTION_RST  = 8'd4;
    localparam logic [2:0] REG_COUNT_RST = 3'd2;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function codes
    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FC_PRESET_MULTI = 8'd16;
    localparam int unsigned FC_EXC_BIT     = 7;

    // Frame layout
    localparam logic [7:0] POS_ID       = 8'd0;
    localparam logic [7:0] POS_FUNCTION = 8'd1;
    localparam logic [7:0] POS_COUNT    = 8'd2;
    localparam logic [7:0] POS_PAYLOAD  = 8'd3;
    localparam logic [7:0] POS_MAX      = 8'hFF;
    localparam logic [8:0] MIN_LENGTH   = 9'd5;

    typedef enum logic [2:0] {
        ST_VALID      = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_BAD_FUNC   = 3'd2,
        ST_BAD_CRC    = 3'd3,
        ST_SHORT      = 3'd4,
        ST_EXCEPTION  = 3'd5,
        ST_BYTE_COUNT = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic [63:0] value;
        logic [3:0]  value_bytes;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] slave_id;
        logic [7:0] function_code;
        logic [2:0] reg_count;
    } t_cfg;

    // One byte of CRC-16 update, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrrc_cfg_regs.sv -----
`default_nettype none

module mrrc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mrrc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mrrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mrrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output mrrc_pkg::t_cfg                      o_cfg
);
    import mrrc_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_id      <= SLAVE_ID_RST;
            r_cfg.function_code <= FUNCTION_RST;
            r_cfg.reg_count     <= REG_COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SLAVE_ID:  r_cfg.slave_id      <= pwdata[7:0];
                REG_FUNCTION:  r_cfg.function_code <= pwdata[7:0];
                REG_REG_COUNT: r_cfg.reg_count     <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_SLAVE_ID:  prdata = {24'h0, r_cfg.slave_id};
            REG_FUNCTION:  prdata = {24'h0, r_cfg.function_code};
            REG_REG_COUNT: prdata = {29'h0, r_cfg.reg_count};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/mrrc_frame_judge.sv -----
`default_nettype none

module mrrc_frame_judge #(
    parameter int unsigned MAX_VALUE_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  mrrc_pkg::t_in_beat       i_beat,
    input  mrrc_pkg::t_cfg           i_cfg,
    output mrrc_pkg::t_out_beat      o_result
);
    import mrrc_pkg::*;

    localparam int unsigned PW = 8 * MAX_VALUE_BYTES;

    logic [15:0]   r_crc,     n_crc;
    logic [7:0]    r_pos,     n_pos;
    logic [7:0]    r_id,      n_id;
    logic [7:0]    r_func,    n_func;
    logic [7:0]    r_count,   n_count;
    logic [PW-1:0] r_payload, n_payload;

    logic [7:0] pay_off;
    logic [8:0] length;
    logic       count_ok;

    // Advance frame state by one byte
    always_comb begin
        n_crc     = crc16_byte(r_crc, i_beat.rx_byte);
        n_pos     = (r_pos == POS_MAX) ? r_pos : r_pos + 8'd1;
        n_id      = r_id;
        n_func    = r_func;
        n_count   = r_count;
        n_payload = r_payload;
        pay_off   = r_pos - POS_PAYLOAD;
        priority if (r_pos == POS_ID) begin
            n_id = i_beat.rx_byte;
        end else if (r_pos == POS_FUNCTION) begin
            n_func = i_beat.rx_byte;
        end else if (r_pos == POS_COUNT) begin
            n_count = i_beat.rx_byte;
        end else if (pay_off < r_count && pay_off < 8'(MAX_VALUE_BYTES)) begin
            n_payload = {r_payload[PW-9:0], i_beat.rx_byte};
        end
    end

    // Judge the frame on its last byte
    assign length   = {1'b0, r_pos} + 9'd1;
    assign count_ok = (r_count == {4'h0, i_cfg.reg_count, 1'b0})
                   && (r_count <= 8'(MAX_VALUE_BYTES))
                   && (length >= {1'b0, r_count} + MIN_LENGTH);

    always_comb begin
        o_result = '0;
        priority if (length < MIN_LENGTH) begin
            o_result.status = ST_SHORT;
        end else if (r_id != i_cfg.slave_id) begin
            o_result.status = ST_BAD_ID;
        end else if (n_crc != 16'h0000) begin
            o_result.status = ST_BAD_CRC;
        end else if (r_func[FC_EXC_BIT]) begin
            o_result.status         = ST_EXCEPTION;
            o_result.exception_code = r_count;
        end else if (r_func != i_cfg.function_code) begin
            o_result.status = ST_BAD_FUNC;
        end else if (r_func == FC_READ_HOLDING || r_func == FC_READ_INPUT) begin
            if (count_ok) begin
                o_result.status      = ST_VALID;
                o_result.value       = 64'(n_payload);
                o_result.value_bytes = r_count[3:0];
            end else begin
                o_result.status = ST_BYTE_COUNT;
            end
        end else if (r_func == FC_PRESET_MULTI) begin
            o_result.status = ST_VALID;
        end else begin
            o_result.status = ST_BAD_FUNC;
        end
    end

    // Hold frame state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.frame_end)) begin
            r_crc     <= CRC_INIT;
            r_pos     <= '0;
            r_id      <= '0;
            r_func    <= '0;
            r_count   <= '0;
            r_payload <= '0;
        end else if (i_step) begin
            r_crc     <= n_crc;
            r_pos     <= n_pos;
            r_id      <= n_id;
            r_func    <= n_func;
            r_count   <= n_count;
            r_payload <= n_payload;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_response_checker_top.sv -----
// The last byte of a frame is captured in the input register; its result is then written
// into the result register and offered on o_out_valid. That last byte waits in the input
// register only while an earlier result is still held.
// Throughput: one byte per cycle, except that a last byte waits as above; the CRC byte
// update and frame checks sit in one stage between the input and result registers.
// Reset (synchronous, active low) empties both registers, restarts the frame and
// loads the configuration defaults.
`default_nettype none

module modbus_rtu_response_checker_top #(
    parameter int unsigned MAX_VALUE_BYTES = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  mrrc_pkg::t_in_beat                   i_in_beat,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mrrc_pkg::t_out_beat                  o_out_beat,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mrrc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mrrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mrrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import mrrc_pkg::*;

    t_cfg      cfg;
    t_out_beat result;
    t_in_beat  r_in_beat;
    t_out_beat r_out_beat;
    logic      r_in_valid;
    logic      r_out_valid;
    logic      out_free;
    logic      step;

    mrrc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mrrc_frame_judge #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in_beat),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Only the last byte needs room in the result register
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_in_beat.frame_end || out_free);
    assign o_in_ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_beat.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_beat.frame_end) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // A last byte that advances always produces a result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_beat.frame_end |=> o_out_valid)
        else $error("last byte advanced without a result");

    // Payload only travels with a valid status
    a_value_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != ST_VALID
            |-> o_out_beat.value == 64'h0 && o_out_beat.value_bytes == 4'h0)
        else $error("payload reported with an error status");

    // Exception code only on an exception reply
    a_exc_only_exception: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != ST_EXCEPTION
            |-> o_out_beat.exception_code == 8'h00)
        else $error("exception code without exception status");

    // Payload length never exceeds the value register
    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.value_bytes <= 4'(MAX_VALUE_BYTES))
        else $error("value_bytes exceeds payload capacity");

endmodule

`default_nettype wire

// ----- tb/mrrc_tb_pkg.sv -----
package mrrc_tb_pkg;

    import mrrc_pkg::*;

    localparam int unsigned PAYLOAD_MAX  = 8;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    // Advance a reflected CRC-16 by one byte, feeding data bits LSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ data[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Tracks the frame under way and queues the verdict of every closed frame
    class frame_judge;
        t_cfg        cfg;
        logic [15:0] crc_acc;
        logic [7:0]  byte_pos;
        logic [7:0]  id_seen;
        logic [7:0]  func_seen;
        logic [7:0]  count_seen;
        logic [63:0] payload_acc;
        t_out_beat   due_verdicts[$];
        int unsigned errors;

        function new();
            cfg.slave_id      = SLAVE_ID_RST;
            cfg.function_code = FUNCTION_RST;
            cfg.reg_count     = REG_COUNT_RST;
            errors            = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            crc_acc     = CRC_INIT;
            byte_pos    = '0;
            id_seen     = '0;
            func_seen   = '0;
            count_seen  = '0;
            payload_acc = '0;
        endfunction

        // Mirror a register write; the spare index is dropped
        function void write_reg(input logic [1:0] index, input logic [31:0] data);
            case (index)
                REG_SLAVE_ID:  cfg.slave_id      = data[7:0];
                REG_FUNCTION:  cfg.function_code = data[7:0];
                REG_REG_COUNT: cfg.reg_count     = data[2:0];
                default: ;
            endcase
        endfunction

        // Fold in one accepted byte beat; judge the frame on its last byte
        function void take_byte(input t_in_beat beat);
            int unsigned pos;
            int unsigned frame_len;
            int unsigned offset;
            t_out_beat   verdict;
            pos     = byte_pos;
            crc_acc = crc16_next(crc_acc, beat.rx_byte);
            if (pos == POS_ID) begin
                id_seen = beat.rx_byte;
            end else if (pos == POS_FUNCTION) begin
                func_seen = beat.rx_byte;
            end else if (pos == POS_COUNT) begin
                count_seen = beat.rx_byte;
            end else begin
                offset = pos - POS_PAYLOAD;
                if (offset < count_seen && offset < PAYLOAD_MAX) begin
                    payload_acc = {payload_acc[55:0], beat.rx_byte};
                end
            end
            if (byte_pos != POS_MAX) begin
                byte_pos = byte_pos + 8'd1;
            end
            if (!beat.frame_end) begin
                return;
            end

            frame_len = pos + 1;
            verdict   = '0;
            if (frame_len < MIN_LENGTH) begin
                verdict.status = ST_SHORT;
            end else if (id_seen != cfg.slave_id) begin
                verdict.status = ST_BAD_ID;
            end else if (crc_acc != 16'h0000) begin
                verdict.status = ST_BAD_CRC;
            end else if (func_seen[FC_EXC_BIT]) begin
                verdict.status         = ST_EXCEPTION;
                verdict.exception_code = count_seen;
            end else if (func_seen != cfg.function_code) begin
                verdict.status = ST_BAD_FUNC;
            end else if (func_seen == FC_READ_HOLDING || func_seen == FC_READ_INPUT) begin
                if (int'(count_seen) == 2 * int'(cfg.reg_count) &&
                    int'(count_seen) <= PAYLOAD_MAX &&
                    frame_len >= int'(count_seen) + int'(MIN_LENGTH)) begin
                    verdict.status      = ST_VALID;
                    verdict.value       = payload_acc;
                    verdict.value_bytes = count_seen[3:0];
                end else begin
                    verdict.status = ST_BYTE_COUNT;
                end
            end else if (func_seen == FC_PRESET_MULTI) begin
                verdict.status = ST_VALID;
            end else begin
                verdict.status = ST_BAD_FUNC;
            end
            due_verdicts.push_back(verdict);
            restart_frame();
        endfunction

        function void log_error(input string msg);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%s", msg);
            end
        endfunction

        // Compare one result beat with the oldest verdict due
        function void match_verdict(input t_out_beat got);
            t_out_beat want;
            if (due_verdicts.size() == 0) begin
                log_error($sformatf("unexpected result: status %0d exc %02h value %016h bytes %0d",
                                    got.status, got.exception_code, got.value, got.value_bytes));
                return;
            end
            want = due_verdicts.pop_front();
            if (got.status !== want.status || got.exception_code !== want.exception_code ||
                got.value !== want.value || got.value_bytes !== want.value_bytes) begin
                log_error($sformatf({"result mismatch: expected status %0d exc %02h value %016h",
                                     " bytes %0d, got status %0d exc %02h value %016h bytes %0d"},
                                    want.status, want.exception_code, want.value,
                                    want.value_bytes, got.status, got.exception_code,
                                    got.value, got.value_bytes));
            end
        endfunction

        function int unsigned pending();
            return due_verdicts.size();
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;

    import mrrc_pkg::*;
    import mrrc_tb_pkg::*;

    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PHASE_BYTES   = 180;
    localparam int unsigned LONG_EXTRA    = 270;
    localparam int unsigned NUM_PHASES    = 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // No random idle gaps on either side while set
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    frame_judge judge;

    // Settings per phase: slave id, function code, register count
    t_cfg phase_cfg [NUM_PHASES] = '{
        '{8'd0,   FC_READ_HOLDING, 3'd1},
        '{8'd255, FC_READ_INPUT,   3'd4},
        '{8'd17,  FC_PRESET_MULTI, 3'd3},
        '{8'd247, FC_READ_HOLDING, 3'd0},
        '{8'd5,   FC_READ_INPUT,   3'd7},
        '{8'd128, 8'd255,          3'd5},
        '{8'd165, 8'd0,            3'd6},
        '{8'd1,   FC_READ_INPUT,   3'd2}
    };

    modbus_rtu_response_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic void push_random(ref logic [7:0] f[$], input int unsigned count);
        for (int i = 0; i < count; i++) begin
            f.push_back(8'($urandom()));
        end
    endfunction

    // Close a frame with its CRC, low byte first
    function automatic void append_crc(ref logic [7:0] f[$]);
        logic [15:0] acc;
        acc = CRC_INIT;
        foreach (f[i]) begin
            acc = crc16_next(acc, f[i]);
        end
        f.push_back(acc[7:0]);
        f.push_back(acc[15:8]);
    endfunction

    // Mostly replies that fit the current settings, the rest broken or noise
    function automatic void build_frame(input t_cfg c, ref logic [7:0] f[$]);
        int unsigned kind;
        int unsigned n;
        f.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            push_random(f, (kind < 96) ? $urandom_range(1, 4) : $urandom_range(1, 20));
            return;
        end
        f.push_back(c.slave_id);
        if (kind < 55) begin
            f.push_back(c.function_code);
            if (c.function_code == FC_READ_HOLDING || c.function_code == FC_READ_INPUT) begin
                n = 2 * c.reg_count;
                f.push_back(8'(n));
                push_random(f, n);
                if ($urandom_range(0, 9) == 0) begin
                    push_random(f, $urandom_range(1, 4));
                end
            end else if (c.function_code == FC_PRESET_MULTI) begin
                push_random(f, 4);
            end else begin
                push_random(f, $urandom_range(1, 4));
            end
        end else if (kind < 65) begin
            f.push_back(c.function_code | 8'h80);
            push_random(f, 1);
        end else if (kind < 72) begin
            f.push_back(FC_PRESET_MULTI);
            push_random(f, 4);
        end else if (kind < 80) begin
            // count off or payload cut short
            n = $urandom_range(0, 10);
            f.push_back($urandom_range(0, 1) ? c.function_code : FC_READ_HOLDING);
            f.push_back(8'(n));
            push_random(f, $urandom_range(0, n));
        end else if (kind < 86) begin
            f[0] = c.slave_id ^ 8'($urandom_range(1, 255));
            f.push_back(c.function_code);
            push_random(f, $urandom_range(1, 4));
        end else begin
            push_random(f, $urandom_range(1, 6));
        end
        append_crc(f);
        // flip one bit now and then
        if ($urandom_range(0, 11) == 0) begin
            n = $urandom_range(0, f.size() - 1);
            f[n] = f[n] ^ (8'h01 << $urandom_range(0, 7));
        end
    endfunction

    // Offer one byte beat and hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_beat.rx_byte   <= b;
        i_in_beat.frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_frame(input logic [7:0] f[$]);
        foreach (f[i]) begin
            send_beat(f[i], i == f.size() - 1);
        end
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        judge.write_reg(index, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a phase's settings, with junk in the unused upper bits
    task automatic apply_settings(input t_cfg c);
        apb_write(REG_SLAVE_ID, {24'($urandom()), c.slave_id});
        apb_write(REG_FUNCTION, {24'($urandom()), c.function_code});
        apb_write(REG_REG_COUNT, {29'($urandom()), c.reg_count});
        apb_write(REG_UNUSED, $urandom());
    endtask

    // Drop valid, wait for every verdict due, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (judge.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Accept-side monitor: feed byte beats to the predictor, check result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                judge.take_byte(i_in_beat);
            end
            if (o_out_valid && i_out_ready) begin
                judge.match_verdict(o_out_beat);
            end
        end
    end

    // Result sink with random stalls and one long hold-off on request
    initial begin : result_sink
        int unsigned gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            gap = idle_gap();
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // End the run once nothing has moved for too long
    initial begin : watchdog
        int unsigned still_cycles;
        still_cycles = 0;
        while (still_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                still_cycles = 0;
            end else begin
                still_cycles++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  frame [$];
        int unsigned sent;
        bit          hold_sent;
        judge     = new();
        hold_sent = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed replies under the reset settings
        frame = '{8'h01, FC_READ_INPUT, 8'h04, 8'h00, 8'hFF, 8'h80, 8'h7F};
        append_crc(frame);
        send_frame(frame);
        frame = '{8'h01, 8'h84, 8'h02};
        append_crc(frame);
        send_frame(frame);
        frame = '{8'h01, FC_READ_INPUT, 8'h02};
        send_frame(frame);
        frame = '{8'hFF};
        send_frame(frame);
        frame = '{8'hFF, FC_READ_INPUT, 8'h00};
        append_crc(frame);
        send_frame(frame);
        settle();

        // Random replies, one batch per setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            steady = (ph == 0 || ph == 4);
            apply_settings(phase_cfg[ph]);
            sent = 0;
            if (ph == 1) begin
                // long reply that runs the byte position into saturation
                frame.delete();
                frame.push_back(phase_cfg[ph].slave_id);
                frame.push_back(phase_cfg[ph].function_code);
                frame.push_back(8'(2 * phase_cfg[ph].reg_count));
                push_random(frame, PAYLOAD_MAX + LONG_EXTRA);
                append_crc(frame);
                send_frame(frame);
                sent += frame.size();
            end
            while (sent < PHASE_BYTES) begin
                if (ph == 0 && !hold_sent && sent >= 40) begin
                    hold_request = 1'b1;
                    hold_sent    = 1'b1;
                end
                build_frame(phase_cfg[ph], frame);
                send_frame(frame);
                sent += frame.size();
            end
            settle();
        end

        if (judge.errors == 0 && judge.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
